### rtl/core/kte_pkg.sv
package kte_pkg;

   // Byte codes used in the emitted sequences
   localparam logic [7:0] ByteEsc     = 8'h1b;
   localparam logic [7:0] ByteBracket = 8'h5b;   // '['
   localparam logic [7:0] ByteO       = 8'h4f;   // 'O'
   localparam logic [7:0] ByteOne     = 8'h31;   // '1'
   localparam logic [7:0] ByteSemi    = 8'h3b;   // ';'
   localparam logic [7:0] ByteTilde   = 8'h7e;   // '~'
   localparam logic [7:0] ByteZero    = 8'h30;   // '0'
   localparam logic [7:0] CtrlMask    = 8'h1f;

   // Request kinds
   localparam logic ReqText = 1'b0;
   localparam logic ReqKey  = 1'b1;

   // Modifier bit positions
   localparam int ModShift = 0;
   localparam int ModAlt   = 1;
   localparam int ModCtrl  = 2;

   // Register map: word index taken from paddr[2]
   localparam int  CsrAddrWidth      = 3;
   localparam logic CsrIdxCursorMode = 1'b0;

   // Queue depth between the classifier and the byte sequencer
   localparam int QueueDepthDefault = 2;

   localparam int MaxSeqLen = 6;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_LIT    = 2'd1,
      KIND_CURSOR = 2'd2,
      KIND_NUM    = 2'd3
   } key_kind_type;

   typedef struct packed {
      key_kind_type kind;
      logic [7:0]   ch;
      logic [2:0]   num;
   } key_entry_type;

   // One encoded item: bytes in order, length 0..6 (0 when nothing is emitted)
   typedef struct packed {
      logic [MaxSeqLen-1:0][7:0] seq_bytes;
      logic [2:0]                seq_len;
   } seq_word_type;

   // Special key table, indexed by key code
   function automatic key_entry_type key_lookup(input logic [4:0] code);
      key_entry_type e;
      begin
         e = '{kind: KIND_NONE, ch: 8'h00, num: 3'd0};
         unique case (code)
            5'd1:    e = '{kind: KIND_LIT,    ch: 8'h0a, num: 3'd0};
            5'd2:    e = '{kind: KIND_LIT,    ch: 8'h09, num: 3'd0};
            5'd3:    e = '{kind: KIND_LIT,    ch: 8'h08, num: 3'd0};
            5'd4:    e = '{kind: KIND_LIT,    ch: 8'h1b, num: 3'd0};
            5'd5:    e = '{kind: KIND_CURSOR, ch: 8'h41, num: 3'd0};
            5'd6:    e = '{kind: KIND_CURSOR, ch: 8'h42, num: 3'd0};
            5'd7:    e = '{kind: KIND_CURSOR, ch: 8'h44, num: 3'd0};
            5'd8:    e = '{kind: KIND_CURSOR, ch: 8'h43, num: 3'd0};
            5'd9:    e = '{kind: KIND_NUM,    ch: 8'h7e, num: 3'd2};
            5'd10:   e = '{kind: KIND_NUM,    ch: 8'h7e, num: 3'd3};
            5'd11:   e = '{kind: KIND_CURSOR, ch: 8'h48, num: 3'd0};
            5'd12:   e = '{kind: KIND_CURSOR, ch: 8'h46, num: 3'd0};
            5'd13:   e = '{kind: KIND_NUM,    ch: 8'h7e, num: 3'd5};
            5'd14:   e = '{kind: KIND_NUM,    ch: 8'h7e, num: 3'd6};
            default: e = '{kind: KIND_NONE,   ch: 8'h00, num: 3'd0};
         endcase
         return e;
      end
   endfunction

endpackage

### rtl/core/kte_front.sv
module kte_front (
   input  logic                  req_type,
   input  logic [7:0]            text_byte,
   input  logic                  single_char,
   input  logic [4:0]            key_code,
   input  logic [2:0]            modifiers,
   input  logic                  cursor_key_mode,
   output logic                  seq_nonempty,
   output kte_pkg::seq_word_type seq_word
);
   import kte_pkg::*;

   key_entry_type entry;
   logic [7:0]    mod_char;
   logic [1:0]    noshift;

   assign entry    = key_lookup(key_code);
   assign mod_char = ByteOne + {5'd0, modifiers};
   assign noshift  = modifiers[ModCtrl:ModAlt];

   // Classify the word and build its byte sequence
   always_comb begin
      seq_word.seq_bytes = '0;
      seq_word.seq_len   = 3'd0;
      if (req_type == ReqText) begin
         if (noshift == 2'b00) begin
            seq_word.seq_bytes[0] = text_byte;
            seq_word.seq_len      = 3'd1;
         end else if (noshift == 2'b10 && single_char) begin
            seq_word.seq_bytes[0] = text_byte & CtrlMask;
            seq_word.seq_len      = 3'd1;
         end
      end else begin
         unique case (entry.kind)
            KIND_LIT: begin
               seq_word.seq_bytes[0] = entry.ch;
               seq_word.seq_len      = 3'd1;
            end
            KIND_CURSOR: begin
               seq_word.seq_bytes[0] = ByteEsc;
               if (cursor_key_mode) begin
                  seq_word.seq_bytes[1] = ByteO;
                  seq_word.seq_bytes[2] = entry.ch;
                  seq_word.seq_len      = 3'd3;
               end else if (modifiers == 3'd0) begin
                  seq_word.seq_bytes[1] = ByteBracket;
                  seq_word.seq_bytes[2] = entry.ch;
                  seq_word.seq_len      = 3'd3;
               end else begin
                  seq_word.seq_bytes[1] = ByteBracket;
                  seq_word.seq_bytes[2] = ByteOne;
                  seq_word.seq_bytes[3] = ByteSemi;
                  seq_word.seq_bytes[4] = mod_char;
                  seq_word.seq_bytes[5] = entry.ch;
                  seq_word.seq_len      = 3'd6;
               end
            end
            KIND_NUM: begin
               seq_word.seq_bytes[0] = ByteEsc;
               seq_word.seq_bytes[1] = ByteBracket;
               seq_word.seq_bytes[2] = ByteZero + {5'd0, entry.num};
               if (modifiers == 3'd0) begin
                  seq_word.seq_bytes[3] = entry.ch;
                  seq_word.seq_len      = 3'd4;
               end else begin
                  seq_word.seq_bytes[3] = ByteSemi;
                  seq_word.seq_bytes[4] = mod_char;
                  seq_word.seq_bytes[5] = entry.ch;
                  seq_word.seq_len      = 3'd6;
               end
            end
            default: begin
               seq_word.seq_len = 3'd0;
            end
         endcase
      end
   end

   assign seq_nonempty = (seq_word.seq_len != 3'd0);

endmodule

### rtl/core/kte_queue.sv
module kte_queue #(
   parameter int Depth = kte_pkg::QueueDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kte_pkg::seq_word_type push_word,
   input  logic                  pop,
   output kte_pkg::seq_word_type head_word,
   output logic                  empty,
   output logic                  full
);
   import kte_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   seq_word_type          mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff == FullCnt);
   assign head_word = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/core/kte_back.sv
module kte_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  kte_pkg::seq_word_type head_word,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte
);
   import kte_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = head_valid && (!valid_ff || !rsp_stall);
   assign at_end = (idx_ff == head_word.seq_len - 3'd1);
   assign pop    = load && at_end;

   // Step through the head word one byte per cycle while the output is not stalled
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_word.seq_bytes[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the output byte while stalled
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

### rtl/core/key_to_escape_sequence_encoder_top.sv
// The first byte of a word passes through the queue and then the output register
// before it is valid. The sequencer sends one byte per cycle while rsp_stall is low;
// a word gives 1 to 6 bytes, and a word that gives no bytes is dropped at the input.
// The queue between classifier and sequencer sets overlap.
// Reset: synchronous, active high; clears the queue, the output stage and
// cursor_key_mode.
module key_to_escape_sequence_encoder_top #(
   parameter int QueueDepth = kte_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_req_type,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_single_char,
   input  logic [4:0]                        req_key_code,
   input  logic [2:0]                        req_modifiers,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_byte,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kte_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import kte_pkg::*;

   logic         cursor_mode_ff, cursor_mode_in;
   logic         csr_write;
   logic         csr_idx;
   logic         accept;
   logic         seq_nonempty;
   seq_word_type seq_word;
   seq_word_type head_word;
   logic         q_empty;
   logic         q_full;
   logic         pop;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cursor_mode_in = cursor_mode_ff;
      if (csr_write && csr_idx == CsrIdxCursorMode) begin
         cursor_mode_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == CsrIdxCursorMode) begin
         csr_prdata = {31'd0, cursor_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_mode_ff <= 1'b0;
      end else begin
         cursor_mode_ff <= cursor_mode_in;
      end
   end

   // Accept a word whenever the queue has room; drop empty encodings
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   kte_front u_front (
      .req_type        (req_req_type),
      .text_byte       (req_text_byte),
      .single_char     (req_single_char),
      .key_code        (req_key_code),
      .modifiers       (req_modifiers),
      .cursor_key_mode (cursor_mode_ff),
      .seq_nonempty    (seq_nonempty),
      .seq_word        (seq_word)
   );

   kte_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && seq_nonempty),
      .push_word (seq_word),
      .pop       (pop),
      .head_word (head_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   kte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (!q_empty),
      .head_word     (head_word),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
